>>> hdl/mlfb_pkg.sv
package mlfb_pkg;

    typedef logic [3:0] step_t;
    typedef logic [3:0] op_t;
    typedef logic [3:0] cond_t;

    // datapath operations
    localparam op_t OP_NOP    = 4'd0;
    localparam op_t OP_CLR    = 4'd1;
    localparam op_t OP_IDLE   = 4'd2;
    localparam op_t OP_LOADA  = 4'd3;
    localparam op_t OP_LOADB  = 4'd4;
    localparam op_t OP_FIXB   = 4'd5;
    localparam op_t OP_PIXRD  = 4'd6;
    localparam op_t OP_PIXWR  = 4'd7;
    localparam op_t OP_FLINIT = 4'd8;
    localparam op_t OP_FLRD   = 4'd9;
    localparam op_t OP_FLSH   = 4'd10;
    localparam op_t OP_FLOUT  = 4'd11;

    // jump conditions
    localparam cond_t C_NEVER      = 4'd0;
    localparam cond_t C_ALWAYS     = 4'd1;
    localparam cond_t C_CLR_BUSY   = 4'd2;
    localparam cond_t C_NO_ACCEPT  = 4'd3;
    localparam cond_t C_NOT_LOAD   = 4'd4;
    localparam cond_t C_NOT_WLAST  = 4'd5;
    localparam cond_t C_NOT_PIX    = 4'd6;
    localparam cond_t C_NOT_FLUSH  = 4'd7;
    localparam cond_t C_BEAT_OPEN  = 4'd8;
    localparam cond_t C_OUT_BUSY   = 4'd9;
    localparam cond_t C_FLUSH_MORE = 4'd10;

    // program steps
    localparam step_t ST_CLR    = 4'd0;
    localparam step_t ST_IDLE   = 4'd1;
    localparam step_t ST_DISP   = 4'd2;
    localparam step_t ST_LOADA  = 4'd3;
    localparam step_t ST_LOADB  = 4'd4;
    localparam step_t ST_FIXB   = 4'd5;
    localparam step_t ST_PIXRD  = 4'd6;
    localparam step_t ST_PIXWR  = 4'd7;
    localparam step_t ST_FLCHK  = 4'd8;
    localparam step_t ST_FLINIT = 4'd9;
    localparam step_t ST_FLRD   = 4'd10;
    localparam step_t ST_FLSH   = 4'd11;
    localparam step_t ST_FLOUT  = 4'd12;
    localparam step_t ST_FLNEXT = 4'd13;
    localparam step_t ST_RET    = 4'd14;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic clr_busy;
        logic no_accept;
        logic not_load;
        logic not_wlast;
        logic not_pix;
        logic not_flush;
        logic beat_open;
        logic out_busy;
        logic flush_more;
    } flags_t;

    // item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // stream kinds
    localparam logic [1:0] KIND_RAW  = 2'd0;
    localparam logic [1:0] KIND_HELD = 2'd1;
    localparam logic [1:0] KIND_BMP  = 2'd2;

    localparam logic [7:0] BMP_B      = 8'h42;
    localparam logic [7:0] BMP_M      = 8'h4D;
    localparam int         PIX_OFFSET = 62;
    localparam int         HDR_BYTES  = 7;
    localparam logic [7:0] CMD_CTRL   = 8'h80;
    localparam logic [7:0] CMD_ONE    = 8'h01;
    localparam logic [7:0] CMD_DATA   = 8'h40;

    function automatic uword_t ucode(step_t s);
        uword_t w;
        unique case (s)
            ST_CLR:    w = '{OP_CLR,    C_CLR_BUSY,   ST_CLR};
            ST_IDLE:   w = '{OP_IDLE,   C_NO_ACCEPT,  ST_IDLE};
            ST_DISP:   w = '{OP_NOP,    C_NOT_LOAD,   ST_PIXRD};
            ST_LOADA:  w = '{OP_LOADA,  C_NEVER,      ST_IDLE};
            ST_LOADB:  w = '{OP_LOADB,  C_NOT_WLAST,  ST_IDLE};
            ST_FIXB:   w = '{OP_FIXB,   C_ALWAYS,     ST_FLINIT};
            ST_PIXRD:  w = '{OP_PIXRD,  C_NOT_PIX,    ST_FLCHK};
            ST_PIXWR:  w = '{OP_PIXWR,  C_ALWAYS,     ST_IDLE};
            ST_FLCHK:  w = '{OP_NOP,    C_NOT_FLUSH,  ST_IDLE};
            ST_FLINIT: w = '{OP_FLINIT, C_NEVER,      ST_IDLE};
            ST_FLRD:   w = '{OP_FLRD,   C_NEVER,      ST_IDLE};
            ST_FLSH:   w = '{OP_FLSH,   C_BEAT_OPEN,  ST_FLRD};
            ST_FLOUT:  w = '{OP_FLOUT,  C_OUT_BUSY,   ST_FLOUT};
            ST_FLNEXT: w = '{OP_NOP,    C_FLUSH_MORE, ST_FLRD};
            ST_RET:    w = '{OP_NOP,    C_ALWAYS,     ST_IDLE};
            default:   w = '{OP_NOP,    C_ALWAYS,     ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/mlfb_seq.sv
module mlfb_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  mlfb_pkg::flags_t flags,
    output mlfb_pkg::op_t    op
);

    mlfb_pkg::step_t  step_reg;
    mlfb_pkg::step_t  step_next;
    mlfb_pkg::uword_t uw;
    logic             take;

    assign uw = mlfb_pkg::ucode(step_reg);
    assign op = uw.op;

    always_comb
    begin
        unique case (uw.cond)
            mlfb_pkg::C_NEVER:      take = 1'b0;
            mlfb_pkg::C_ALWAYS:     take = 1'b1;
            mlfb_pkg::C_CLR_BUSY:   take = flags.clr_busy;
            mlfb_pkg::C_NO_ACCEPT:  take = flags.no_accept;
            mlfb_pkg::C_NOT_LOAD:   take = flags.not_load;
            mlfb_pkg::C_NOT_WLAST:  take = flags.not_wlast;
            mlfb_pkg::C_NOT_PIX:    take = flags.not_pix;
            mlfb_pkg::C_NOT_FLUSH:  take = flags.not_flush;
            mlfb_pkg::C_BEAT_OPEN:  take = flags.beat_open;
            mlfb_pkg::C_OUT_BUSY:   take = flags.out_busy;
            mlfb_pkg::C_FLUSH_MORE: take = flags.flush_more;
            default:                take = 1'b1;
        endcase
        step_next = take ? uw.target : step_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= mlfb_pkg::ST_CLR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

>>> hdl/mlfb_mem.sv
module mlfb_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata_reg
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

>>> hdl/mono_lcd_page_framebuffer.sv
// channel | direction | handshake              | fields
// in      | receive   | in_valid / in_stall    | mode data_byte write_first write_last
//         |           |                        | pixel_x pixel_y pixel_value
// out     | send      | out_valid / out_stall  | payload byte_count transfer_start
//         |           |                        | transfer_end last
//
// Items are taken only at the sequencer's idle step. A load byte passes the dispatch,
// LOADA and LOADB steps, a pixel write the PIXRD and PIXWR steps; a flush is paced by
// the single read port of the store, a read and a shift step per byte. A last stream
// byte adds one step and then the flush. After reset a clearing pass writes zero to all
// PANEL_HEIGHT/8*PANEL_WIDTH store bytes, one a cycle, before the first item is taken.
// A stalled beat holds in the output register while the next beat is assembled.
module mono_lcd_page_framebuffer #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 32,
    parameter int STREAM_MAX   = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    input  logic        write_first,
    input  logic        write_last,
    input  logic [5:0]  pixel_x,
    input  logic [4:0]  pixel_y,
    input  logic        pixel_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] payload,
    output logic [3:0]  byte_count,
    output logic        transfer_start,
    output logic        transfer_end,
    output logic        last
);

    localparam int PAGES  = PANEL_HEIGHT / 8;
    localparam int STORE  = PAGES * PANEL_WIDTH;
    localparam int AW     = $clog2(STORE);
    localparam int POS_W  = $clog2(STREAM_MAX + 1);
    localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int COL_W  = $clog2(PANEL_WIDTH + 1);
    localparam int TOTAL  = mlfb_pkg::HDR_BYTES + PANEL_WIDTH;
    localparam int FPOS_W = $clog2(TOTAL + 1);
    localparam logic [31:0] HT = 32'(PANEL_HEIGHT);
    localparam logic [31:0] WD = 32'(PANEL_WIDTH);

    function automatic logic [7:0] flip_invert(logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7-i] = b[i];
        end
        return ~r;
    endfunction

    mlfb_pkg::op_t    op;
    mlfb_pkg::flags_t flags;

    // latched item
    logic [1:0] mode_reg;
    logic [7:0] data_reg;
    logic       wlast_reg;
    logic [5:0] x_reg;
    logic [4:0] y_reg;
    logic       val_reg;

    // stream state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       kind_reg, kind_next;
    logic             good_reg, good_next;
    logic [PG_W-1:0]  pg_reg, pg_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] pidx_reg;
    logic          pin_reg;

    // flush state
    logic [PG_W-1:0]   fpage_reg, fpage_next;
    logic [FPOS_W-1:0] fpos_reg, fpos_next;
    logic [3:0]        bcnt_reg, bcnt_next;
    logic [63:0]       beat_reg, beat_next;
    logic              bstart_reg, bstart_next;
    logic              done_reg, done_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] payload_reg;
    logic [3:0]  count_reg;
    logic        tstart_reg, tend_reg, last_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    logic        accept;
    logic        pos_open;
    logic        hdr_ok;
    logic [31:0] pix_full, pidx_full, fl_full;
    logic [7:0]  hdr_byte, byte_in;
    logic        page_end;
    logic        out_load;

    mlfb_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    mlfb_mem #(
        .DEPTH (STORE),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr),
        .rdata_reg (rdata)
    );

    assign in_stall = (op != mlfb_pkg::OP_IDLE);
    assign accept   = in_valid && !in_stall;
    assign pos_open = (32'(pos_reg) < 32'(STREAM_MAX));

    assign pix_full  = 32'(pg_reg) * WD + 32'(col_reg);
    assign pidx_full = 32'(y_reg[4:3]) * WD + 32'(x_reg);
    assign fl_full   = 32'(fpage_reg) * WD + 32'(fpos_reg) - 32'(mlfb_pkg::HDR_BYTES);
    assign page_end  = (32'(fpos_reg) == 32'(TOTAL));
    assign out_load  = (op == mlfb_pkg::OP_FLOUT) && !(out_valid_reg && out_stall);

    assign flags.clr_busy   = (32'(clr_reg) != 32'(STORE - 1));
    assign flags.no_accept  = !accept;
    assign flags.not_load   = (mode_reg != mlfb_pkg::MODE_LOAD);
    assign flags.not_wlast  = !wlast_reg;
    assign flags.not_pix    = (mode_reg != mlfb_pkg::MODE_PIXEL);
    assign flags.not_flush  = (mode_reg != mlfb_pkg::MODE_FLUSH);
    assign flags.beat_open  = (bcnt_reg != 4'd7) && (32'(fpos_reg) + 32'd1 != 32'(TOTAL));
    assign flags.out_busy   = out_valid_reg && out_stall;
    assign flags.flush_more = !done_reg;

    // BMP header fields: width, height, bit count
    always_comb
    begin
        hdr_ok = 1'b1;
        case (32'(pos_reg))
            32'd18: hdr_ok = (data_reg == HT[7:0]);
            32'd19: hdr_ok = (data_reg == HT[15:8]);
            32'd20: hdr_ok = (data_reg == HT[23:16]);
            32'd21: hdr_ok = (data_reg == HT[31:24]);
            32'd22: hdr_ok = (data_reg == WD[7:0]);
            32'd23: hdr_ok = (data_reg == WD[15:8]);
            32'd24: hdr_ok = (data_reg == WD[23:16]);
            32'd25: hdr_ok = (data_reg == WD[31:24]);
            32'd28: hdr_ok = (data_reg == 8'h01);
            32'd29: hdr_ok = (data_reg == 8'h00);
            default: hdr_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        case (32'(fpos_reg))
            32'd1:   hdr_byte = mlfb_pkg::CMD_ONE;
            32'd5:   hdr_byte = mlfb_pkg::CMD_DATA + 8'(fpage_reg);
            32'd6:   hdr_byte = mlfb_pkg::CMD_DATA;
            default: hdr_byte = mlfb_pkg::CMD_CTRL;
        endcase
        byte_in = (32'(fpos_reg) < 32'(mlfb_pkg::HDR_BYTES)) ? hdr_byte : rdata;
    end

    always_comb
    begin
        pos_next       = pos_reg;
        kind_next      = kind_reg;
        good_next      = good_reg;
        pg_next        = pg_reg;
        col_next       = col_reg;
        clr_next       = clr_reg;
        fpage_next     = fpage_reg;
        fpos_next      = fpos_reg;
        bcnt_next      = bcnt_reg;
        beat_next      = beat_reg;
        bstart_next    = bstart_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && out_stall;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        raddr          = pidx_full[AW-1:0];

        unique case (op)
            mlfb_pkg::OP_CLR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            mlfb_pkg::OP_IDLE:
            begin
                if (accept && mode == mlfb_pkg::MODE_LOAD && write_first)
                begin
                    pos_next  = '0;
                    kind_next = mlfb_pkg::KIND_RAW;
                    good_next = 1'b1;
                    pg_next   = '0;
                    col_next  = '0;
                end
            end
            mlfb_pkg::OP_LOADA:
            begin
                // held 'B' not followed by 'M': stream turns raw
                if (pos_open && pos_reg != '0 && kind_reg == mlfb_pkg::KIND_HELD
                    && data_reg != mlfb_pkg::BMP_M)
                begin
                    we        = 1'b1;
                    wdata     = mlfb_pkg::BMP_B;
                    kind_next = mlfb_pkg::KIND_RAW;
                end
            end
            mlfb_pkg::OP_LOADB:
            begin
                if (pos_open)
                begin
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == '0)
                    begin
                        if (data_reg == mlfb_pkg::BMP_B)
                        begin
                            kind_next = mlfb_pkg::KIND_HELD;
                        end
                        else
                        begin
                            kind_next = mlfb_pkg::KIND_RAW;
                            we        = 1'b1;
                            wdata     = data_reg;
                        end
                    end
                    else if (kind_reg == mlfb_pkg::KIND_HELD)
                    begin
                        kind_next = mlfb_pkg::KIND_BMP;
                    end
                    else if (kind_reg == mlfb_pkg::KIND_RAW)
                    begin
                        we    = (32'(pos_reg) < 32'(STORE));
                        waddr = pos_reg[AW-1:0];
                        wdata = data_reg;
                    end
                    else if (32'(pos_reg) < 32'(mlfb_pkg::PIX_OFFSET))
                    begin
                        good_next = good_reg && hdr_ok;
                    end
                    else if (32'(col_reg) < WD)
                    begin
                        we    = good_reg;
                        waddr = pix_full[AW-1:0];
                        wdata = flip_invert(data_reg);
                        if (32'(pg_reg) == 32'(PAGES - 1))
                        begin
                            pg_next  = '0;
                            col_next = col_reg + 1'b1;
                        end
                        else
                        begin
                            pg_next = pg_reg + 1'b1;
                        end
                    end
                end
            end
            mlfb_pkg::OP_FIXB:
            begin
                if (kind_reg == mlfb_pkg::KIND_HELD)
                begin
                    we        = 1'b1;
                    wdata     = mlfb_pkg::BMP_B;
                    kind_next = mlfb_pkg::KIND_RAW;
                end
            end
            mlfb_pkg::OP_PIXRD:
            begin
                raddr = pidx_full[AW-1:0];
            end
            mlfb_pkg::OP_PIXWR:
            begin
                we    = pin_reg;
                waddr = pidx_reg;
                if (val_reg)
                begin
                    wdata = rdata | (8'd1 << y_reg[2:0]);
                end
                else
                begin
                    wdata = rdata & ~(8'd1 << y_reg[2:0]);
                end
            end
            mlfb_pkg::OP_FLINIT:
            begin
                fpage_next  = '0;
                fpos_next   = '0;
                bcnt_next   = '0;
                beat_next   = '0;
                bstart_next = 1'b1;
                done_next   = 1'b0;
            end
            mlfb_pkg::OP_FLRD:
            begin
                raddr = fl_full[AW-1:0];
            end
            mlfb_pkg::OP_FLSH:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    if (bcnt_reg[2:0] == 3'(i))
                    begin
                        beat_next[63-8*i -: 8] = byte_in;
                    end
                end
                bcnt_next = bcnt_reg + 4'd1;
                fpos_next = fpos_reg + 1'b1;
            end
            mlfb_pkg::OP_FLOUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    beat_next      = '0;
                    bcnt_next      = '0;
                    bstart_next    = page_end;
                    if (page_end)
                    begin
                        fpos_next  = '0;
                        fpage_next = fpage_reg + 1'b1;
                        done_next  = (32'(fpage_reg) == 32'(PAGES - 1));
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            kind_reg      <= mlfb_pkg::KIND_RAW;
            good_reg      <= 1'b1;
            pg_reg        <= '0;
            col_reg       <= '0;
            clr_reg       <= '0;
            fpage_reg     <= '0;
            fpos_reg      <= '0;
            bcnt_reg      <= '0;
            bstart_reg    <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            good_reg      <= good_next;
            pg_reg        <= pg_next;
            col_reg       <= col_next;
            clr_reg       <= clr_next;
            fpage_reg     <= fpage_next;
            fpos_reg      <= fpos_next;
            bcnt_reg      <= bcnt_next;
            bstart_reg    <= bstart_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
        if (accept)
        begin
            mode_reg  <= mode;
            data_reg  <= data_byte;
            wlast_reg <= write_last;
            x_reg     <= pixel_x;
            y_reg     <= pixel_y;
            val_reg   <= pixel_value;
        end
        if (op == mlfb_pkg::OP_PIXRD)
        begin
            pidx_reg <= pidx_full[AW-1:0];
            pin_reg  <= (32'(x_reg) < WD) && (32'(y_reg) < HT);
        end
        if (out_load)
        begin
            payload_reg <= beat_reg;
            count_reg   <= bcnt_reg;
            tstart_reg  <= bstart_reg;
            tend_reg    <= page_end;
            last_reg    <= page_end && (32'(fpage_reg) == 32'(PAGES - 1));
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload        = payload_reg;
    assign byte_count     = count_reg;
    assign transfer_start = tstart_reg;
    assign transfer_end   = tend_reg;
    assign last           = last_reg;

endmodule

>>> hdl/mlfb_checker.sv
module mlfb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] payload,
    input logic [3:0]  byte_count,
    input logic        transfer_end,
    input logic        last
);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count >= 4'd1 && byte_count <= 4'd8))
        else $error("byte_count out of range");

    a_short_ends_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count != 4'd8 |-> transfer_end)
        else $error("partial beat before end of page");

    a_last_ends_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> transfer_end)
        else $error("last beat does not end a page");

    a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input taken in the middle of a flush");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload))
        else $error("stalled beat changed");

endmodule

bind mono_lcd_page_framebuffer mlfb_checker u_mlfb_checker (.*);
